[sv/rplz_pkg.sv]
`default_nettype none
package rplz_pkg;

  localparam int unsigned HISTORY_DEPTH = 131072;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned CHUNK_BYTES   = 32;
  localparam int unsigned CNT_W         = $clog2(CHUNK_BYTES) + 1;

  // Opcode range limits
  localparam logic [7:0] OP2_MAX  = 8'h7F;
  localparam logic [7:0] OP3_MAX  = 8'hBF;
  localparam logic [7:0] OP4_MAX  = 8'hDF;
  localparam logic [7:0] OPLR_MAX = 8'hFB;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DIST  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_OP   = 3'd3,
    PH_B1   = 3'd4,
    PH_B2   = 3'd5,
    PH_B3   = 3'd6,
    PH_LIT  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_RD,
    ST_WR,
    ST_FLUSH,
    ST_FIN
  } state_t;

  // Parser state
  typedef struct packed {
    phase_t              phase;
    logic [23:0]         cmd;
    logic [6:0]          lit;
    logic [10:0]         len;
    logic [HIST_AW-1:0]  cdist;
  } parse_st_t;

  // Parser result for one stream word
  typedef struct packed {
    parse_st_t st;
    logic      put;
    logic      run;
  } parse_res_t;

endpackage
`default_nettype wire

[sv/rplz_if.sv]
`default_nettype none
interface rplz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface rplz_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes_0;
  logic [63:0] out_bytes_1;
  logic [63:0] out_bytes_2;
  logic [63:0] out_bytes_3;
  logic [5:0]  byte_count;
  logic        last_of_run;
  logic        end_of_stream;
  logic [1:0]  status;
  modport source (output valid, out_bytes_0, out_bytes_1, out_bytes_2, out_bytes_3,
                  byte_count, last_of_run, end_of_stream, status, input ready);
  modport sink   (input valid, out_bytes_0, out_bytes_1, out_bytes_2, out_bytes_3,
                  byte_count, last_of_run, end_of_stream, status, output ready);
endinterface
`default_nettype wire

[sv/rplz_ram.sv]
`default_nettype none
module rplz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/rplz_parse.sv]
`default_nettype none
module rplz_parse
  import rplz_pkg::*;
(
  input  wire parse_st_t  cur,
  input  wire logic [7:0] in_byte,
  output parse_res_t      res
);

  logic [7:0] b0, b1, b2, b3;
  logic [23:0] cmd;
  logic        fin;

  always_comb begin
    res     = '0;
    res.st  = cur;
    cmd     = cur.cmd;
    fin     = 1'b0;
    b3      = 8'd0;
    unique case (cur.phase)
      PH_HDR0: res.st.phase = PH_HDR1;
      PH_HDR1: res.st.phase = PH_HDR2;
      PH_HDR2: res.st.phase = PH_OP;
      PH_OP: begin
        cmd = {16'd0, in_byte};
        if (in_byte > OP4_MAX) fin = 1'b1;
        else res.st.phase = PH_B1;
      end
      PH_B1: begin
        cmd[15:8] = in_byte;
        if (cmd[7:0] <= OP2_MAX) fin = 1'b1;
        else res.st.phase = PH_B2;
      end
      PH_B2: begin
        cmd[23:16] = in_byte;
        if (cmd[7:0] <= OP3_MAX) fin = 1'b1;
        else res.st.phase = PH_B3;
      end
      PH_B3: begin
        b3  = in_byte;
        fin = 1'b1;
      end
      PH_LIT: begin
        res.put = 1'b1;
        res.st.lit = cur.lit - 7'd1;
        if (res.st.lit == 7'd0) begin
          res.st.phase = PH_OP;
          res.run = 1'b1;
        end
      end
      default: res.st.phase = PH_HDR0;
    endcase
    res.st.cmd = cmd;
    b0 = cmd[7:0];
    b1 = cmd[15:8];
    b2 = cmd[23:16];

    // Decode a complete command
    if (fin) begin
      res.st.len   = 11'd0;
      res.st.cdist = '0;
      if (b0 <= OP2_MAX) begin
        res.st.lit   = {5'd0, b0[1:0]};
        res.st.len   = 11'({b0[4:2]}) + 11'd3;
        res.st.cdist = HIST_AW'({b0[6:5], b1});
      end else if (b0 <= OP3_MAX) begin
        res.st.lit   = {5'd0, b1[7:6]};
        res.st.len   = 11'({b0[5:0]}) + 11'd4;
        res.st.cdist = HIST_AW'({b1[5:0], b2});
      end else if (b0 <= OP4_MAX) begin
        res.st.lit   = {5'd0, b0[1:0]};
        res.st.len   = 11'({b0[3:2], b3}) + 11'd5;
        res.st.cdist = HIST_AW'({b0[4], b1, b2});
      end else if (b0 <= OPLR_MAX) begin
        res.st.lit  = {b0[4:0], 2'b00} + 7'd4;
      end else begin
        res.st.lit  = {5'd0, b0[1:0]};
      end
      if (res.st.lit != 7'd0) begin
        res.st.phase = PH_LIT;
      end else begin
        res.st.phase = PH_OP;
        res.run      = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/refpack_lz_decompressor.sv]
`default_nettype none
// Flow: each stream word is taken in ST_IDLE, then passes ST_CHK and ST_FIN; a
// back-reference copies each byte by a history read (ST_RD), then write (ST_WR),
// with a ST_FLUSH step after each full chunk that more copied bytes follow; a stalled result word holds the flow.
// Throughput: one stream word at a time; copied bytes go one at a time through the
// read-then-write loop on the single history RAM.
// Reset: synchronous, clears parser and output control; history contents stay
// undefined until written and are never read before that.
module refpack_lz_decompressor
  import rplz_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  rplz_in_if.sink    in_ch,
  rplz_out_if.source out_ch
);

  state_t state, state_next;
  parse_st_t  ps;
  parse_res_t pr;

  logic [HIST_AW-1:0] wp;
  logic [HIST_AW:0]   bw;
  logic               error_seen;
  logic               err_now;
  logic               run_req;
  logic               last_r;
  logic [255:0]       buffer;
  logic [CNT_W-1:0]   count;

  logic               out_valid;
  logic [255:0]       out_data;
  logic [CNT_W-1:0]   out_cnt;
  logic               out_lor, out_eos;
  logic [1:0]         out_stat;

  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  logic accept, slot_free, need_out, dist_bad;
  logic [1:0] stat_now;

  rplz_parse u_parse (.cur(ps), .in_byte(in_ch.in_byte), .res(pr));

  rplz_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;
  assign need_out  = (count != '0) || err_now || last_r;
  assign dist_bad  = {1'b0, ps.cdist} >= bw;
  assign stat_now  = error_seen ? STAT_DIST :
                     (last_r && ps.phase != PH_OP) ? STAT_TRUNC : STAT_OK;
  assign ram_raddr = wp - ps.cdist - HIST_AW'(1);

  // Next state and memory control
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wp;
    ram_wdata   = ram_rdata;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = ST_CHK;
          if (!error_seen && pr.put) begin
            ram_we    = 1'b1;
            ram_wdata = in_ch.in_byte;
          end
        end
      end
      ST_CHK: begin
        if (run_req && ps.len != 11'd0 && !dist_bad) state_next = ST_RD;
        else state_next = ST_FIN;
      end
      ST_RD: state_next = ST_WR;
      ST_WR: begin
        ram_we = 1'b1;
        if (ps.len == 11'd1) state_next = ST_FIN;
        else if (count == CNT_W'(CHUNK_BYTES - 1)) state_next = ST_FLUSH;
        else state_next = ST_RD;
      end
      ST_FLUSH: if (slot_free) state_next = ST_RD;
      ST_FIN: if (!need_out || slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Stream state and chunk buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ps         <= '0;
      wp         <= '0;
      bw         <= '0;
      error_seen <= 1'b0;
      err_now    <= 1'b0;
      run_req    <= 1'b0;
      last_r     <= 1'b0;
      buffer     <= '0;
      count      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) begin
          last_r  <= in_ch.last_byte;
          err_now <= 1'b0;
          run_req <= !error_seen && pr.run;
          if (!error_seen) begin
            ps <= pr.st;
            if (pr.put) begin
              buffer[7:0] <= in_ch.in_byte;
              count       <= CNT_W'(1);
              wp          <= wp + HIST_AW'(1);
              if (bw != (HIST_AW+1)'(HISTORY_DEPTH)) bw <= bw + (HIST_AW+1)'(1);
            end
          end
        end
        ST_CHK: if (run_req && ps.len != 11'd0 && dist_bad) begin
          err_now    <= 1'b1;
          error_seen <= 1'b1;
          ps.len     <= 11'd0;
        end
        ST_WR: begin
          buffer[{count[CNT_W-2:0], 3'b000} +: 8] <= ram_rdata;
          count  <= count + CNT_W'(1);
          wp     <= wp + HIST_AW'(1);
          ps.len <= ps.len - 11'd1;
          if (bw != (HIST_AW+1)'(HISTORY_DEPTH)) bw <= bw + (HIST_AW+1)'(1);
        end
        ST_FLUSH: if (slot_free) begin
          buffer <= '0;
          count  <= '0;
        end
        ST_FIN: if (need_out && slot_free) begin
          buffer <= '0;
          count  <= '0;
          if (last_r) begin
            ps         <= '0;
            wp         <= '0;
            bw         <= '0;
            error_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free && (state == ST_FLUSH || (state == ST_FIN && need_out))) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && (state == ST_FLUSH || (state == ST_FIN && need_out))) begin
      out_data <= buffer;
      out_cnt  <= count;
      out_lor  <= (state == ST_FIN);
      out_eos  <= (state == ST_FIN) && last_r;
      out_stat <= (state == ST_FIN) ? stat_now : STAT_OK;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_bytes_0   = out_data[63:0];
  assign out_ch.out_bytes_1   = out_data[127:64];
  assign out_ch.out_bytes_2   = out_data[191:128];
  assign out_ch.out_bytes_3   = out_data[255:192];
  assign out_ch.byte_count    = 6'(out_cnt);
  assign out_ch.last_of_run   = out_lor;
  assign out_ch.end_of_stream = out_eos;
  assign out_ch.status        = out_stat;

endmodule
`default_nettype wire

[tb/tb_refpack_lz_decompressor.sv]
`default_nettype none
module tb_refpack_lz_decompressor;
  import rplz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [7:0] b;
    bit         last;
  } stream_word_t;

  typedef struct {
    logic [255:0] data;
    logic [5:0]   cnt;
    bit           lor;
    bit           eos;
    logic [1:0]   status;
  } chunk_t;

  logic clk;
  logic rst;

  rplz_in_if  in_ch();
  rplz_out_if out_ch();

  refpack_lz_decompressor DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stream_word_t pend_words[$];
  chunk_t       exp_chunks[$];
  int           n_words;
  int           errors;
  int           idle_cycles;

  // Decoder mirror state
  logic [7:0]  hist [HISTORY_DEPTH];
  logic [16:0] wr_pos;
  int          hist_fill;
  phase_t      ph;
  logic [23:0] cmd;
  int          lits_left;
  int          cp_len;
  int          cp_dist;
  bit          err_seen;
  logic [7:0]  step_bytes[$];

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int pick_gap(bit burst);
    if (burst || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Decoder mirror
  task automatic emit(logic [7:0] b);
    hist[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    if (hist_fill < HISTORY_DEPTH) hist_fill++;
    step_bytes.push_back(b);
  endtask

  task automatic replay_copy(output bit ok);
    int i;
    ok = 1'b1;
    if (cp_len == 0) return;
    if (cp_dist + 1 > hist_fill) begin
      cp_len = 0;
      ok = 1'b0;
      return;
    end
    for (i = 0; i < cp_len; i++) emit(hist[17'(wr_pos - 17'(cp_dist + 1))]);
    cp_len = 0;
  endtask

  task automatic decode_cmd(logic [7:0] b3, output bit ok);
    logic [7:0] b0, b1, b2;
    int span;
    b0 = cmd[7:0];
    b1 = cmd[15:8];
    b2 = cmd[23:16];
    span = 1;
    cp_len = 0;
    ok = 1'b1;
    if (b0 <= OP2_MAX) begin
      lits_left = b0 & 3;
      cp_len = ((b0 & 8'h1C) >> 2) + 3;
      span = ((b0 & 8'h60) << 3) + b1 + 1;
    end else if (b0 <= OP3_MAX) begin
      lits_left = b1 >> 6;
      cp_len = (b0 & 8'h3F) + 4;
      span = ((b1 & 8'h3F) << 8) + b2 + 1;
    end else if (b0 <= OP4_MAX) begin
      lits_left = b0 & 3;
      cp_len = ((b0 & 8'h0C) << 6) + b3 + 5;
      span = ((b0 & 8'h10) << 12) + (b1 << 8) + b2 + 1;
    end else if (b0 <= OPLR_MAX) begin
      lits_left = ((b0 & 8'h1F) << 2) + 4;
    end else begin
      lits_left = b0 & 3;
    end
    cp_dist = span - 1;
    if (lits_left > 0) begin
      ph = PH_LIT;
    end else begin
      ph = PH_OP;
      replay_copy(ok);
    end
  endtask

  function automatic int cmd_size(logic [7:0] b0);
    if (b0 <= OP2_MAX) return 2;
    if (b0 <= OP3_MAX) return 3;
    if (b0 <= OP4_MAX) return 4;
    return 1;
  endfunction

  task automatic clear_stream();
    wr_pos = '0;
    hist_fill = 0;
    ph = PH_HDR0;
    cmd = '0;
    lits_left = 0;
    cp_len = 0;
    cp_dist = 0;
    err_seen = 1'b0;
  endtask

  task automatic decode_word(logic [7:0] b, bit last);
    bit ok, report;
    logic [1:0] st;
    int chunks, k, i, base, cnt;
    chunk_t c;
    ok = 1'b1;
    report = 1'b0;
    st = STAT_OK;
    step_bytes.delete();
    if (!err_seen) begin
      case (ph)
        PH_HDR0: ph = PH_HDR1;
        PH_HDR1: ph = PH_HDR2;
        PH_HDR2: ph = PH_OP;
        PH_OP: begin
          cmd = {16'h0, b};
          if (cmd_size(b) == 1) decode_cmd(8'h0, ok);
          else ph = PH_B1;
        end
        PH_B1: begin
          cmd[15:8] = b;
          if (cmd_size(cmd[7:0]) == 2) decode_cmd(8'h0, ok);
          else ph = PH_B2;
        end
        PH_B2: begin
          cmd[23:16] = b;
          if (cmd_size(cmd[7:0]) == 3) decode_cmd(8'h0, ok);
          else ph = PH_B3;
        end
        PH_B3: decode_cmd(b, ok);
        default: begin
          emit(b);
          if (lits_left > 0) lits_left--;
          if (lits_left == 0) begin
            ph = PH_OP;
            replay_copy(ok);
          end
        end
      endcase
      if (!ok) begin
        err_seen = 1'b1;
        report = 1'b1;
      end
    end
    if (err_seen) st = STAT_DIST;
    else if (last && ph != PH_OP) st = STAT_TRUNC;
    if (last) begin
      report = 1'b1;
      clear_stream();
    end
    chunks = (step_bytes.size() + CHUNK_BYTES - 1) / CHUNK_BYTES;
    if (chunks == 0) begin
      if (!report) return;
      chunks = 1;
    end
    for (k = 0; k < chunks; k++) begin
      base = k * CHUNK_BYTES;
      cnt = step_bytes.size() > base ? step_bytes.size() - base : 0;
      if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
      c.data = '0;
      for (i = 0; i < cnt; i++) c.data[i*8 +: 8] = step_bytes[base + i];
      c.cnt = 6'(cnt);
      c.lor = (k + 1 == chunks);
      c.eos = c.lor && last;
      c.status = c.lor ? st : STAT_OK;
      exp_chunks.push_back(c);
    end
  endtask

  // Stimulus helpers
  task automatic put_word(logic [7:0] b, bit last = 1'b0);
    stream_word_t w;
    w.b = b;
    w.last = last;
    pend_words.push_back(w);
    n_words++;
  endtask

  task automatic put_header();
    repeat (3) put_word(8'($urandom));
  endtask

  // One random stream; bad injects a distance past the output, trunc cuts a command
  task automatic gen_stream(int ncmd, bit bad, bit trunc);
    int produced, n, kind, lit, maxd, span, d1, j, lenhi, bad_at, cmin;
    produced = 0;
    bad_at = bad ? $urandom_range(0, ncmd - 1) : -1;
    put_header();
    for (n = 0; n < ncmd; n++) begin
      kind = $urandom_range(0, 9);
      lit = $urandom_range(0, 3);
      cmin = 0;
      if (produced + lit == 0) lit = 1;
      if (kind < 2) begin
        // literal run
        if ($urandom_range(0, 3) == 0) put_word(8'hE0 + 8'($urandom_range(0, 27)));
        else put_word(8'hE0 + 8'($urandom_range(0, 2)));
        lit = ((pend_words[$].b & 8'h1F) << 2) + 4;
      end else if (kind == 2) begin
        put_word(8'hFC + 8'($urandom_range(0, 3)));
        lit = pend_words[$].b & 3;
      end else begin
        if (kind < 6) maxd = 1024;
        else if (kind < 8) maxd = 16384;
        else maxd = 131072;
        if (n == bad_at) begin
          span = produced + lit + 1 + $urandom_range(0, 40);
          if (span > maxd) span = maxd;
        end else begin
          if (maxd > produced + lit) maxd = produced + lit;
          span = $urandom_range(1, maxd);
        end
        d1 = span - 1;
        if (kind < 6) begin
          cmin = 3;
          put_word(8'(((d1 >> 8) << 5) | ($urandom_range(0, 7) << 2) | lit));
          put_word(8'(d1));
        end else if (kind < 8) begin
          cmin = 4;
          put_word(8'h80 | 8'($urandom_range(0, 63)));
          put_word(8'((lit << 6) | ((d1 >> 8) & 8'h3F)));
          put_word(8'(d1));
        end else begin
          cmin = 5;
          lenhi = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 0;
          put_word(8'(8'hC0 | (((d1 >> 16) & 1) << 4) | (lenhi << 2) | lit));
          put_word(8'(d1 >> 8));
          put_word(8'(d1));
          put_word(8'($urandom));
        end
      end
      for (j = 0; j < lit; j++) put_word(8'($urandom));
      produced += lit + cmin;
    end
    if (trunc) begin
      case ($urandom_range(0, 3))
        0: put_word(8'h80 | 8'($urandom_range(0, 63)));
        1: put_word(8'h00 | 8'($urandom_range(0, 127)));
        2: put_word(8'hC0 | 8'($urandom_range(0, 31)));
        default: put_word(8'hE0);
      endcase
    end
    pend_words[$].last = 1'b1;
  endtask

  // Stimulus
  initial begin
    int k;
    n_words = 0;
    errors = 0;
    clear_stream();
    // literal runs, extremes of the byte, overlapping copy, every command form
    put_word(8'h00); put_word(8'hFF); put_word(8'h10);
    put_word(8'hE0); put_word(8'h00); put_word(8'hFF); put_word(8'h55); put_word(8'hAA);
    put_word(8'hFD); put_word(8'h7E);
    put_word(8'h00); put_word(8'h00);
    put_word(8'h81); put_word(8'h40); put_word(8'h02); put_word(8'h3C);
    put_word(8'hCF); put_word(8'h00); put_word(8'h00); put_word(8'hFF);
    put_word(8'h01); put_word(8'h02); put_word(8'h03);
    put_word(8'hFF); put_word(8'h11); put_word(8'h22); put_word(8'h33, 1'b1);
    // distance past the output, then ignored words
    put_header(); put_word(8'h00); put_word(8'h05); put_word(8'hE0); put_word(8'h12, 1'b1);
    // ends inside a command, inside the header, and on a lone word
    put_header(); put_word(8'h80, 1'b1);
    put_word(8'h00); put_word(8'h01, 1'b1);
    put_word(8'hFF, 1'b1);
    // random streams, mostly well formed
    while (n_words < 120) begin
      k = $urandom_range(0, 9);
      if (k == 0) repeat ($urandom_range(1, 8)) put_word(8'($urandom), $urandom_range(0, 7) == 0);
      else gen_stream($urandom_range(1, 8), k == 1, k == 2);
    end
    if (!pend_words[$].last) pend_words[$].last = 1'b1;

    // drain
    while (pend_words.size() != 0 || in_ch.valid !== 1'b0 || rst) @(posedge clk);
    while (exp_chunks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stream word driver
  int  in_gap;
  bit  in_burst;
  stream_word_t cur;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= '0;
      in_ch.last_byte <= 1'b0;
      in_gap = 0;
      in_burst = 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pend_words.size() != 0) begin
        cur = pend_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= cur.b;
        in_ch.last_byte <= cur.last;
        in_gap = pick_gap(in_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink stalls
  int  out_stall;
  bit  out_burst;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
      out_burst = 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = pick_gap(out_burst);
      end
    end
  end

  // Predict on accepted stream words, check accepted results
  chunk_t want;
  logic [255:0] got;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) decode_word(in_ch.in_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_bytes_3, out_ch.out_bytes_2, out_ch.out_bytes_1, out_ch.out_bytes_0};
        if (exp_chunks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, count %0d data %h", $time,
                   out_ch.byte_count, got);
        end else begin
          want = exp_chunks.pop_front();
          if (got !== want.data) begin
            errors++;
            $display("%0t: data expected %h actual %h", $time, want.data, got);
          end
          if (out_ch.byte_count !== want.cnt) begin
            errors++;
            $display("%0t: byte_count expected %0d actual %0d", $time, want.cnt,
                     out_ch.byte_count);
          end
          if (out_ch.last_of_run !== want.lor) begin
            errors++;
            $display("%0t: last_of_run expected %0d actual %0d", $time, want.lor,
                     out_ch.last_of_run);
          end
          if (out_ch.end_of_stream !== want.eos) begin
            errors++;
            $display("%0t: end_of_stream expected %0d actual %0d", $time, want.eos,
                     out_ch.end_of_stream);
          end
          if (out_ch.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_ch.status);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire
